// ===== design/sitoa_pkg.sv =====
// Shared types and constants for the signed integer to decimal ASCII unit.
// No dependencies; imported by sitoa_dabble and the top level.
package sitoa_pkg;

    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 7;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);
    localparam int LEFT_W     = $clog2(BCD_DIGITS + 1);

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;

    // Commands from the sequencer to the BCD shift register
    typedef struct packed {
        logic load;        // take a fresh magnitude and start converting
        logic digit_shift; // drop the top BCD digit, move the rest up
    } dab_ctrl_t;

    // Status back to the sequencer
    typedef struct packed {
        logic       conv_done; // no conversion in progress
        logic [3:0] top_digit; // most significant BCD digit
    } dab_stat_t;

endpackage

// ===== design/sitoa_dabble.sv =====
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
// Depends on sitoa_pkg for widths and the control/status structs.
module sitoa_dabble (
    input  logic                               clk,
    input  logic                               rst_n,
    input  sitoa_pkg::dab_ctrl_t               ctrl,
    input  logic [sitoa_pkg::VALUE_W-1:0]      magnitude,
    output sitoa_pkg::dab_stat_t               stat
);
    import sitoa_pkg::*;

    logic [VALUE_W-1:0]   bin_reg, bin_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [BCD_W-1:0]     bcd_adj;
    logic [BIT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 active_reg, active_next;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        bin_next    = bin_reg;
        bcd_next    = bcd_reg;
        cnt_next    = cnt_reg;
        active_next = active_reg;
        priority if (ctrl.load)
        begin
            bin_next    = magnitude;
            bcd_next    = '0;
            cnt_next    = BIT_CNT_W'(VALUE_W - 1);
            active_next = 1'b1;
        end
        else if (active_reg)
        begin
            bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
            bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
                active_next = 1'b0;
        end
        else if (ctrl.digit_shift)
        begin
            bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign stat.conv_done = !active_reg;
    assign stat.top_digit = bcd_reg[BCD_W-1 -: 4];

endmodule

// ===== design/signed_int_to_decimal_ascii_unit.sv =====
// Top level: signed 32-bit integer to decimal ASCII text, one character per strobe.
// Depends on sitoa_pkg and sitoa_dabble.
//
// Pulse start while busy is low to hand over one item on value. The unit then
// shows the decimal text of that value on character, most significant first,
// one character per clock cycle with strobe high; a negative value starts with
// '-', zero gives the single character '0', and -2147483648 comes out exactly.
// last is high with the final character of the run. Each character is on the
// ports for exactly one cycle and must be captured then: there is no way to
// hold the output off. Busy stays high while an item is worked on: the
// bit-serial shift-and-add-3 conversion in the BCD shift register (the
// hand-over plus one shift per value bit), the dropping of each leading
// zero digit plus one decision step, the sign if the value is negative,
// and the digits emitted. The final character appears in the cycle in
// which busy is already low, so the next item may be started then.
module signed_int_to_decimal_ascii_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [sitoa_pkg::VALUE_W-1:0]  value,
    output logic                                  strobe,
    output logic [sitoa_pkg::CHAR_W-1:0]          character,
    output logic                                  last
);
    import sitoa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_SIGN,
        S_EMIT
    } state_t;

    state_t              state_reg, state_next;
    logic                neg_reg, neg_next;
    logic [LEFT_W-1:0]   left_reg, left_next;
    logic                strobe_reg, strobe_next;
    logic                last_reg, last_next;
    logic [CHAR_W-1:0]   char_reg, char_next;

    logic                accept;
    logic [VALUE_W-1:0]  raw;
    logic [VALUE_W-1:0]  magnitude;
    dab_ctrl_t           dab_ctrl;
    dab_stat_t           dab_stat;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // Unsigned magnitude; the most negative value maps onto 2^31 with no overflow
    assign raw       = value;
    assign magnitude = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;

    sitoa_dabble u_dabble (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (dab_ctrl),
        .magnitude (magnitude),
        .stat      (dab_stat)
    );

    always_comb
    begin
        state_next           = state_reg;
        neg_next             = neg_reg;
        left_next            = left_reg;
        strobe_next          = 1'b0;
        last_next            = 1'b0;
        char_next            = char_reg;
        dab_ctrl.load        = 1'b0;
        dab_ctrl.digit_shift = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    // take the item: sign aside, magnitude into the converter
                    dab_ctrl.load = 1'b1;
                    neg_next      = raw[VALUE_W-1];
                    left_next     = LEFT_W'(BCD_DIGITS);
                    state_next    = S_CONV;
                end
            end
            S_CONV:
            begin
                if (dab_stat.conv_done)
                    state_next = S_SKIP;
            end
            S_SKIP:
            begin
                // drop leading zeros, but always keep the units digit
                if (dab_stat.top_digit == 4'd0 && left_reg != LEFT_W'(1))
                begin
                    dab_ctrl.digit_shift = 1'b1;
                    left_next            = left_reg - 1'b1;
                end
                else if (neg_reg)
                    state_next = S_SIGN;
                else
                    state_next = S_EMIT;
            end
            S_SIGN:
            begin
                strobe_next = 1'b1;
                char_next   = ASCII_MINUS;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                // emit the top digit, then advance to the next one
                strobe_next          = 1'b1;
                char_next            = ASCII_ZERO + CHAR_W'(dab_stat.top_digit);
                last_next            = (left_reg == LEFT_W'(1));
                dab_ctrl.digit_shift = 1'b1;
                left_next            = left_reg - 1'b1;
                if (left_reg == LEFT_W'(1))
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            neg_reg    <= 1'b0;
            left_reg   <= '0;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            neg_reg    <= neg_next;
            left_reg   <= left_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
    end

    assign strobe    = strobe_reg;
    assign character = char_reg;
    assign last      = last_reg;

    // last only ever marks a character that is actually shown
    a_last_with_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> strobe)
        else $error("last without strobe");

    // a character that is not the final one leaves the sequencer still working
    a_mid_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |-> busy)
        else $error("run ended without a last character");

    // conversion always separates an accepted item from its first character
    a_accept_no_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !strobe)
        else $error("character shown straight after accept");

    // the final character is never followed directly by another
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !strobe)
        else $error("character directly after last");

endmodule

// ===== bench/signed_int_to_decimal_ascii_unit_tb.sv =====
// Self-checking bench for signed_int_to_decimal_ascii_unit: integers in, decimal ASCII text out.
// Depends on sitoa_pkg and the unit under test; nothing else is read or needed.
`timescale 1ns / 100ps

module signed_int_to_decimal_ascii_unit_tb;

    import sitoa_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int RESET_CYCLES = 7;
    // Cycles without any item taken or any character shown before giving up.
    localparam int QUIET_LIMIT = 1000;
    // Cycles to keep watching once the text of every item has arrived.
    localparam int TAIL_CYCLES = 60;
    localparam int RANDOM_ITEMS = 95;

    // One character of the expected text
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              lst;
    } text_char_t;

    // One item waiting to be handed to the unit
    typedef struct {
        logic [VALUE_W-1:0] word;
        bit                 drain_first; // hold it back until all text has come out
    } value_item_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic signed [VALUE_W-1:0]  value = '0;
    logic                       busy;
    logic                       strobe;
    logic [CHAR_W-1:0]          character;
    logic                       last;

    value_item_t value_items[$];
    text_char_t  expected_text[$];

    int unsigned issued_cnt = 0;   // items placed on the ports by the driver
    int unsigned accepted_cnt = 0; // items the unit has taken
    int unsigned quiet_cycles = 0;
    int unsigned error_cnt = 0;
    int          gap_left = 0;
    int          burst_left = 0;

    signed_int_to_decimal_ascii_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .value     (value),
        .strobe    (strobe),
        .character (character),
        .last      (last)
    );

    always #HALF_PERIOD clk = ~clk;

    // Predict the text of one word: optional minus sign, then the digits of
    // the magnitude, most significant first. The magnitude is formed as an
    // unsigned 32-bit negation, so the most negative value needs no special path.
    task automatic push_decimal_text(input logic [VALUE_W-1:0] word);
        logic [VALUE_W-1:0] mag;
        logic [3:0]         digit [BCD_DIGITS];
        int                 n_dig;
        text_char_t         c;
        mag = word[VALUE_W-1] ? (~word + 1'b1) : word;
        n_dig = 0;
        do
        begin
            digit[n_dig] = 4'(mag % 10);
            mag = mag / 10;
            n_dig++;
        end while (mag != 0 && n_dig < BCD_DIGITS);
        if (word[VALUE_W-1])
        begin
            c.ch = ASCII_MINUS;
            c.lst = 1'b0;
            expected_text.push_back(c);
        end
        for (int k = n_dig - 1; k >= 0; k--)
        begin
            c.ch = ASCII_ZERO + CHAR_W'(digit[k]);
            c.lst = (k == 0);
            expected_text.push_back(c);
        end
    endtask

    task automatic add_value(input logic [VALUE_W-1:0] word, input bit drain_first);
        value_item_t it;
        it.word = word;
        it.drain_first = drain_first;
        value_items.push_back(it);
    endtask

    // The next item may go out unless it asks for the text to drain first
    function automatic bit next_item_ready();
        if (value_items.size() == 0)
            return 1'b0;
        return !value_items[0].drain_first || expected_text.size() == 0;
    endfunction

    // Draw the sender's wait after an item; now and then run a burst with no gaps
    function automatic int draw_gap();
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0)
        begin
            burst_left = $urandom_range(4, 12);
            return 0;
        end
        return $urandom_range(0, 7);
    endfunction

    task automatic present_next_item();
        value_item_t it;
        it = value_items.pop_front();
        start <= 1'b1;
        value <= it.word;
        issued_cnt++;
    endtask

    // Driver: change inputs at the falling edge only. An item counts as taken
    // once the monitor has seen start high with busy low at the rising edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (start && accepted_cnt == issued_cnt)
            begin
                gap_left = draw_gap();
                // keep start high straight into the next item if no gap is due
                if (gap_left == 0 && next_item_ready())
                    present_next_item();
                else
                    start <= 1'b0;
            end
            else if (!start)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (next_item_ready())
                    present_next_item();
            end
        end
    end

    // Monitor: sample at the rising edge. Check any character shown against
    // the oldest expectation first, then queue the text of a newly taken item,
    // since the final character of one item may share the edge that takes the next.
    always @(posedge clk)
    begin : monitor
        bit         quiet;
        text_char_t exp_c;
        if (rst_n)
        begin
            quiet = 1'b1;
            if (strobe)
            begin
                quiet = 1'b0;
                if (expected_text.size() == 0)
                begin
                    $error("unexpected character %0d with last %0b", character, last);
                    error_cnt++;
                end
                else
                begin
                    exp_c = expected_text.pop_front();
                    if (character !== exp_c.ch)
                    begin
                        $error("character mismatch: expected %0d, got %0d", exp_c.ch, character);
                        error_cnt++;
                    end
                    if (last !== exp_c.lst)
                    begin
                        $error("last mismatch: expected %0b, got %0b", exp_c.lst, last);
                        error_cnt++;
                    end
                end
            end
            if (start && !busy)
            begin
                quiet = 1'b0;
                push_decimal_text(value);
                accepted_cnt <= accepted_cnt + 1;
            end
            quiet_cycles <= quiet ? quiet_cycles + 1 : 0;
        end
    end

    initial
    begin
        int unsigned pow10 [10];
        int unsigned mag;
        int          kind;
        bit          timed_out;
        int          tail;

        pow10[0] = 1;
        for (int k = 1; k < 10; k++)
            pow10[k] = pow10[k-1] * 10;

        // Directed items: zero, single digits, the extremes of the range,
        // the most negative value and the digit count edges at ten and at one billion.
        add_value(32'd0, 1'b0);
        add_value(32'd1, 1'b0);
        add_value(-32'sd1, 1'b0);
        add_value(32'd9, 1'b0);
        add_value(32'd10, 1'b0);
        add_value(-32'sd10, 1'b0);
        add_value(32'h7FFF_FFFF, 1'b0);
        add_value(32'h8000_0000, 1'b0);
        add_value(32'h8000_0001, 1'b0);
        add_value(32'd999_999_999, 1'b0);
        add_value(32'd1_000_000_000, 1'b0);
        add_value(-32'sd999_999_999, 1'b0);
        add_value(-32'sd1_000_000_000, 1'b0);
        add_value(32'd123_456_789, 1'b0);
        add_value(32'h5555_5555, 1'b0);
        add_value(32'hAAAA_AAAA, 1'b0);
        // hold the sender back until all of the text above has come out
        add_value(32'd0, 1'b1);

        // Random items: full-range words to flip every bit, small values,
        // values just around each power of ten, and values near the ends.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3: mag = $urandom;
                4, 5:       mag = $urandom_range(0, 999);
                6, 7:       mag = pow10[$urandom_range(0, 9)] + $urandom_range(0, 2) - 1;
                8:          mag = 32'h7FFF_FFFF - $urandom_range(0, 3);
                default:    mag = $urandom_range(0, 99_999);
            endcase
            if (kind != 0 && kind != 1 && kind != 2 && kind != 3 && $urandom_range(0, 1))
                mag = -mag;
            if (kind == 8 && $urandom_range(0, 3) == 0)
                mag = 32'h8000_0000;
            add_value(mag, (n % 30) == 29);
        end

        // Reset once, then release it at a falling edge
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for every item to go in, then for all its text to come out
        timed_out = 1'b0;
        while (!timed_out && (value_items.size() != 0 || accepted_cnt != issued_cnt
                              || expected_text.size() != 0))
        begin
            @(posedge clk);
            if (quiet_cycles >= QUIET_LIMIT)
                timed_out = 1'b1;
        end

        // Watch a little longer for stray characters
        tail = 0;
        while (!timed_out && tail < TAIL_CYCLES)
        begin
            @(posedge clk);
            tail++;
        end

        if (expected_text.size() != 0)
        begin
            $error("%0d expected characters never arrived", expected_text.size());
            error_cnt++;
        end

        if (!timed_out && error_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== signed_int_to_decimal_ascii_unit.f =====
design/sitoa_pkg.sv
design/sitoa_dabble.sv
design/signed_int_to_decimal_ascii_unit.sv
bench/signed_int_to_decimal_ascii_unit_tb.sv
